/* sv/cmfuv_pkg.sv */
// ---------------------------------------------------------------------------
// cmfuv_pkg: shared definitions for the cube map face UV block
// Field widths, axis codes and the structs that travel between the
// front end, the divider chain and the output stage.
// ---------------------------------------------------------------------------
package cmfuv_pkg;

   // fixed field widths
   localparam int DIR_W  = 16;   // signed Q1.15 direction component
   localparam int COORD_W = 16;  // unsigned face coordinate field
   localparam int AXIS_W = 2;
   localparam int MAG_W  = 16;   // |component|, up to 32768

   // default fraction bits of the face coordinate
   localparam int COORD_FRAC_BITS_DEF = 16;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // face selection results, carried alongside the division
   typedef struct packed {
      axis_type axis;
      logic     major_neg;
      logic     degen;
   } face_type;

   // divisor and running remainders of the two coordinate lanes
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] rem_u;
      logic [MAG_W-1:0] rem_v;
   } div_type;

endpackage

/* sv/cmfuv_req_if.sv */
// ---------------------------------------------------------------------------
// cmfuv_req_if: direction request channel
// Valid/ready channel carrying one 3D view direction per transfer.
// ---------------------------------------------------------------------------
interface cmfuv_req_if;
   import cmfuv_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic signed [DIR_W-1:0] dir_z;

   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

/* sv/cmfuv_rsp_if.sv */
// ---------------------------------------------------------------------------
// cmfuv_rsp_if: face coordinate response channel
// Valid/ready channel carrying one face selection and UV pair per transfer.
// ---------------------------------------------------------------------------
interface cmfuv_rsp_if;
   import cmfuv_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] tex_u;
   logic [COORD_W-1:0] tex_v;
   logic [AXIS_W-1:0]  major_axis;
   logic               major_negative;
   logic               degenerate;

   modport source (output valid, output tex_u, output tex_v, output major_axis,
                   output major_negative, output degenerate, input ready);
   modport sink   (input valid, input tex_u, input tex_v, input major_axis,
                   input major_negative, input degenerate, output ready);
endinterface

/* sv/cmfuv_front.sv */
// ---------------------------------------------------------------------------
// cmfuv_front: face selection and divider setup
// Stage 1 picks the major axis and the two minor components. Stage 2 applies
// the mirror sign and splits each numerator into its integer quotient part
// and the first remainder for the divider chain.
// ---------------------------------------------------------------------------
module cmfuv_front #(
   parameter int COORD_FRAC_BITS = cmfuv_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [cmfuv_pkg::DIR_W-1:0] in_x,
   input  logic signed [cmfuv_pkg::DIR_W-1:0] in_y,
   input  logic signed [cmfuv_pkg::DIR_W-1:0] in_z,
   output logic                               out_valid,
   input  logic                               out_ready,
   output cmfuv_pkg::face_type                out_face,
   output cmfuv_pkg::div_type                 out_div,
   output logic [COORD_FRAC_BITS+1:0]         out_q_u,
   output logic [COORD_FRAC_BITS+1:0]         out_q_v
);
   import cmfuv_pkg::*;

   localparam int QW = COORD_FRAC_BITS + 2;   // quotient: 2 integer + fraction
   localparam int SW = MAG_W + 2;              // signed minor term width

   typedef struct packed {
      face_type                face;
      logic [MAG_W-1:0]        mag;
      logic signed [DIR_W-1:0] cu;
      logic signed [DIR_W-1:0] cv;
      logic                    flip;
   } sel_type;

   typedef struct packed {
      logic [1:0]       ip;
      logic [MAG_W-1:0] rem;
   } start_type;

   // magnitude of a Q1.15 component; the most negative code gives 32768
   function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIR_W-1:0] v);
      logic [MAG_W-1:0] raw;
      raw = MAG_W'(v);
      return v[DIR_W-1] ? MAG_W'(~raw + 1'b1) : raw;
   endfunction

   // numerator m + sc, with |sc| <= m: integer part of (m + sc) / m and the
   // remainder below m
   function automatic start_type split_num(input logic signed [SW-1:0] sc,
                                           input logic [MAG_W-1:0] mag);
      logic signed [SW-1:0] mag_ext;
      logic signed [SW-1:0] sum;
      start_type            res;
      mag_ext = SW'({2'b00, mag});
      sum     = mag_ext + sc;
      if (sc[SW-1]) begin
         res.ip  = 2'd0;
         res.rem = sum[MAG_W-1:0];
      end else if (sc == mag_ext) begin
         res.ip  = 2'd2;
         res.rem = '0;
      end else begin
         res.ip  = 2'd1;
         res.rem = sc[MAG_W-1:0];
      end
      return res;
   endfunction

   logic      s1_valid_ff, s1_valid_in;
   sel_type   s1_ff, s1_in;
   logic      s2_valid_ff, s2_valid_in;
   face_type  s2_face_ff, s2_face_in;
   div_type   s2_div_ff, s2_div_in;
   logic [QW-1:0] s2_q_u_ff, s2_q_u_in;
   logic [QW-1:0] s2_q_v_ff, s2_q_v_in;

   logic s1_ready, s2_ready;

   logic [MAG_W-1:0]        abs_x, abs_y, abs_z;
   axis_type                axis;
   logic signed [DIR_W-1:0] major;
   logic [MAG_W-1:0]        mag;
   logic                    pos;
   sel_type                 sel;
   logic signed [SW-1:0]    cu_ext, cv_ext, sc_u, sc_v;
   start_type               st_u, st_v;

   // stage ready chain
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // major axis selection: z only when strictly largest, then y when strictly above x, else x
   always_comb begin
      abs_x = mag_of(in_x);
      abs_y = mag_of(in_y);
      abs_z = mag_of(in_z);
      if (abs_z > abs_x && abs_z > abs_y) begin
         axis  = AXIS_Z;
         major = in_z;
         mag   = abs_z;
      end else if (abs_y > abs_x) begin
         axis  = AXIS_Y;
         major = in_y;
         mag   = abs_y;
      end else begin
         axis  = AXIS_X;
         major = in_x;
         mag   = abs_x;
      end
      pos                 = !major[DIR_W-1] && (major != '0);
      sel.face.axis       = axis;
      sel.face.major_neg  = !pos;
      sel.face.degen      = (mag == '0);
      sel.mag             = mag;
      sel.cu              = (axis == AXIS_X) ? in_z : in_x;
      sel.cv              = (axis == AXIS_Y) ? in_z : in_y;
      sel.flip            = (pos != (axis != AXIS_Z));
   end

   always_comb begin
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s1_in       = (s1_ready && in_valid) ? sel : s1_ff;
   end

   // mirror sign and divider setup; v is always flipped
   always_comb begin
      cu_ext = SW'(s1_ff.cu);
      cv_ext = SW'(s1_ff.cv);
      sc_u   = s1_ff.flip ? -cu_ext : cu_ext;
      sc_v   = -cv_ext;
      st_u   = split_num(sc_u, s1_ff.mag);
      st_v   = split_num(sc_v, s1_ff.mag);

      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      if (s2_ready && s1_valid_ff) begin
         s2_face_in      = s1_ff.face;
         s2_div_in.mag   = s1_ff.mag;
         s2_div_in.rem_u = st_u.rem;
         s2_div_in.rem_v = st_v.rem;
         s2_q_u_in       = {{(QW-2){1'b0}}, st_u.ip};
         s2_q_v_in       = {{(QW-2){1'b0}}, st_v.ip};
      end else begin
         s2_face_in = s2_face_ff;
         s2_div_in  = s2_div_ff;
         s2_q_u_in  = s2_q_u_ff;
         s2_q_v_in  = s2_q_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      s2_face_ff <= s2_face_in;
      s2_div_ff  <= s2_div_in;
      s2_q_u_ff  <= s2_q_u_in;
      s2_q_v_ff  <= s2_q_v_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_face  = s2_face_ff;
   assign out_div   = s2_div_ff;
   assign out_q_u   = s2_q_u_ff;
   assign out_q_v   = s2_q_v_ff;

endmodule

/* sv/cmfuv_cell.sv */
// ---------------------------------------------------------------------------
// cmfuv_cell: one restoring division step
// Resolves one quotient bit of both coordinate lanes against the shared
// major magnitude and hands remainders and partial quotients to the next cell.
// ---------------------------------------------------------------------------
module cmfuv_cell #(
   parameter int COORD_FRAC_BITS = cmfuv_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  cmfuv_pkg::face_type        in_face,
   input  cmfuv_pkg::div_type         in_div,
   input  logic [COORD_FRAC_BITS+1:0] in_q_u,
   input  logic [COORD_FRAC_BITS+1:0] in_q_v,
   output logic                       out_valid,
   input  logic                       out_ready,
   output cmfuv_pkg::face_type        out_face,
   output cmfuv_pkg::div_type         out_div,
   output logic [COORD_FRAC_BITS+1:0] out_q_u,
   output logic [COORD_FRAC_BITS+1:0] out_q_v
);
   import cmfuv_pkg::*;

   localparam int QW = COORD_FRAC_BITS + 2;

   // doubled remainder compared with the divisor; result stays below it
   function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
                                               input logic [MAG_W-1:0] mag);
      logic [MAG_W:0] t;
      logic [MAG_W:0] d;
      logic           ge;
      t  = {rem, 1'b0};
      ge = (t >= {1'b0, mag});
      d  = t - {1'b0, mag};
      return ge ? {1'b1, d[MAG_W-1:0]} : {1'b0, t[MAG_W-1:0]};
   endfunction

   logic          valid_ff, valid_in;
   face_type      face_ff, face_in;
   div_type       div_ff, div_in;
   logic [QW-1:0] q_u_ff, q_u_in;
   logic [QW-1:0] q_v_ff, q_v_in;
   logic [MAG_W:0] step_u, step_v;
   logic          load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   // one quotient bit per lane
   always_comb begin
      step_u   = div_step(in_div.rem_u, in_div.mag);
      step_v   = div_step(in_div.rem_v, in_div.mag);
      valid_in = in_ready ? in_valid : valid_ff;
      if (load) begin
         face_in      = in_face;
         div_in.mag   = in_div.mag;
         div_in.rem_u = step_u[MAG_W-1:0];
         div_in.rem_v = step_v[MAG_W-1:0];
         q_u_in       = {in_q_u[QW-2:0], step_u[MAG_W]};
         q_v_in       = {in_q_v[QW-2:0], step_v[MAG_W]};
      end else begin
         face_in = face_ff;
         div_in  = div_ff;
         q_u_in  = q_u_ff;
         q_v_in  = q_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      face_ff <= face_in;
      div_ff  <= div_in;
      q_u_ff  <= q_u_in;
      q_v_ff  <= q_v_in;
   end

   assign out_valid = valid_ff;
   assign out_face  = face_ff;
   assign out_div   = div_ff;
   assign out_q_u   = q_u_ff;
   assign out_q_v   = q_v_ff;

endmodule

/* sv/cmfuv_round.sv */
// ---------------------------------------------------------------------------
// cmfuv_round: rounding, saturation and output register
// Halves the extended quotient with round-half-up, saturates 1.0 to the
// largest code, clears the coordinates of an all-zero direction and holds
// the result until it is taken.
// ---------------------------------------------------------------------------
module cmfuv_round #(
   parameter int COORD_FRAC_BITS = cmfuv_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  cmfuv_pkg::face_type            in_face,
   input  logic [COORD_FRAC_BITS+1:0]     in_q_u,
   input  logic [COORD_FRAC_BITS+1:0]     in_q_v,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [cmfuv_pkg::COORD_W-1:0]  out_u,
   output logic [cmfuv_pkg::COORD_W-1:0]  out_v,
   output logic [cmfuv_pkg::AXIS_W-1:0]   out_axis,
   output logic                           out_neg,
   output logic                           out_degen
);
   import cmfuv_pkg::*;

   localparam int QW = COORD_FRAC_BITS + 2;
   localparam logic [QW-1:0] CODE_MAX = {2'b00, {COORD_FRAC_BITS{1'b1}}};

   // (q + 1) / 2, clamped to the largest code, fitted to the field width
   function automatic logic [COORD_W-1:0] finish(input logic [QW-1:0] q);
      logic [QW:0]           sum;
      logic [QW-1:0]         half;
      logic [QW+COORD_W-1:0] wide;
      sum  = {1'b0, q} + 1'b1;
      half = sum[QW:1];
      if (half > CODE_MAX) begin
         half = CODE_MAX;
      end
      wide = {{COORD_W{1'b0}}, half};
      return wide[COORD_W-1:0];
   endfunction

   logic               valid_ff, valid_in;
   logic [COORD_W-1:0] u_ff, u_in;
   logic [COORD_W-1:0] v_ff, v_in;
   face_type           face_ff, face_in;
   logic               load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      if (load) begin
         face_in = in_face;
         u_in    = in_face.degen ? '0 : finish(in_q_u);
         v_in    = in_face.degen ? '0 : finish(in_q_v);
      end else begin
         face_in = face_ff;
         u_in    = u_ff;
         v_in    = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      face_ff <= face_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
   end

   assign out_valid = valid_ff;
   assign out_u     = u_ff;
   assign out_v     = v_ff;
   assign out_axis  = face_ff.axis;
   assign out_neg   = face_ff.major_neg;
   assign out_degen = face_ff.degen;

endmodule

/* sv/cube_map_face_uv.sv */
// Takes one direction per cycle while the response side is not stalled and
// returns one face result per direction, in order. Two front stages pick the
// major axis and set up the divisions, a chain of COORD_FRAC_BITS division
// cells resolves one quotient bit of u and v in each cell, and a final
// register rounds and saturates. Every stage has its own valid bit, so empty
// stages keep taking requests while a finished response waits to be taken.
// ---------------------------------------------------------------------------
// cube_map_face_uv: cube map direction to face UV
// Selects the cube face of a signed Q1.15 direction and computes the face
// coordinates as unsigned fixed point in [0, 1), with axis and sign flags.
// ---------------------------------------------------------------------------
module cube_map_face_uv #(
   parameter int COORD_FRAC_BITS = cmfuv_pkg::COORD_FRAC_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   cmfuv_req_if.sink    req_ch,
   cmfuv_rsp_if.source  rsp_ch
);
   import cmfuv_pkg::*;

   localparam int QW    = COORD_FRAC_BITS + 2;
   localparam int CELLS = COORD_FRAC_BITS;

   // chain taps: index 0 is the front end output, CELLS the last cell
   logic          tap_valid [0:CELLS];
   logic          tap_ready [0:CELLS];
   face_type      tap_face  [0:CELLS];
   div_type       tap_div   [0:CELLS];
   logic [QW-1:0] tap_q_u   [0:CELLS];
   logic [QW-1:0] tap_q_v   [0:CELLS];

   // face selection and divider setup
   cmfuv_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_x      (req_ch.dir_x),
      .in_y      (req_ch.dir_y),
      .in_z      (req_ch.dir_z),
      .out_valid (tap_valid[0]),
      .out_ready (tap_ready[0]),
      .out_face  (tap_face[0]),
      .out_div   (tap_div[0]),
      .out_q_u   (tap_q_u[0]),
      .out_q_v   (tap_q_v[0])
   );

   // division chain, one quotient bit per cell
   for (genvar k = 0; k < CELLS; k++) begin : g_chain
      cmfuv_cell #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (tap_valid[k]),
         .in_ready  (tap_ready[k]),
         .in_face   (tap_face[k]),
         .in_div    (tap_div[k]),
         .in_q_u    (tap_q_u[k]),
         .in_q_v    (tap_q_v[k]),
         .out_valid (tap_valid[k+1]),
         .out_ready (tap_ready[k+1]),
         .out_face  (tap_face[k+1]),
         .out_div   (tap_div[k+1]),
         .out_q_u   (tap_q_u[k+1]),
         .out_q_v   (tap_q_v[k+1])
      );
   end

   // rounding and response register
   cmfuv_round #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tap_valid[CELLS]),
      .in_ready  (tap_ready[CELLS]),
      .in_face   (tap_face[CELLS]),
      .in_q_u    (tap_q_u[CELLS]),
      .in_q_v    (tap_q_v[CELLS]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_u     (rsp_ch.tex_u),
      .out_v     (rsp_ch.tex_v),
      .out_axis  (rsp_ch.major_axis),
      .out_neg   (rsp_ch.major_negative),
      .out_degen (rsp_ch.degenerate)
   );

   // an all-zero direction reports zero coordinates
   a_degen_zero_uv : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.degenerate) |-> (rsp_ch.tex_u == '0 && rsp_ch.tex_v == '0))
      else $error("degenerate response with nonzero coordinates");

   // an all-zero direction falls to the x face with a non-positive major
   a_degen_face : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.degenerate) |->
         (rsp_ch.major_axis == AXIS_X && rsp_ch.major_negative))
      else $error("degenerate response with wrong face flags");

   // coordinates never exceed the saturated code at narrow fraction widths
   a_coord_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (COORD_FRAC_BITS >= COORD_W) ||
         ((rsp_ch.tex_u >> COORD_FRAC_BITS) == '0 && (rsp_ch.tex_v >> COORD_FRAC_BITS) == '0))
      else $error("face coordinate above saturation code");

   // the last cell hands over a remainder below the divisor
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (tap_valid[CELLS] && !tap_face[CELLS].degen) |->
         (tap_div[CELLS].rem_u < tap_div[CELLS].mag && tap_div[CELLS].rem_v < tap_div[CELLS].mag))
      else $error("division remainder out of range");

endmodule
